// File: sv/aptq_pkg.sv
// ----------------------------------------------------------------------------
// aptq_pkg
// Types, constants and status codes for the aging priority task queue.
// ----------------------------------------------------------------------------
package aptq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int AGE_BITS_DEF  = 16;
    localparam int PRIO_BITS_DEF = 8;

    localparam logic [2:0] ST_QUEUED  = 3'd0;
    localparam logic [2:0] ST_GRANTED = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_CALLER  = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;
    localparam logic [2:0] ST_REFUSED = 3'd5;

    localparam logic [1:0] POL_REJECT  = 2'd0;
    localparam logic [1:0] POL_CALLER  = 2'd1;
    localparam logic [1:0] POL_DROPNEW = 2'd2;
    localparam logic [1:0] POL_DISCARD = 2'd3;

    localparam logic [1:0] REG_POLICY    = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_CAPACITY  = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [15:0] task_id;
        logic [7:0]  priority_req;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_task;
        logic [7:0]  out_priority;
        logic        reject_error;
        logic [4:0]  occupancy;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic scan_clr;  // start a scan pass
        logic scan_step; // examine one entry
        logic decide;    // pick winner after the oldest pass
        logic commit;    // update storage and build result
        logic compact;   // one step of the order fix-up pass
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic need_scan;
        logic prio_pass;
        logic fix_last;
        logic need_fix;
    } dp_sts_t;

endpackage

// File: sv/aptq_datapath.sv
// ----------------------------------------------------------------------------
// aptq_datapath
// Entry storage, serial scan comparator and result register.
// ----------------------------------------------------------------------------
module aptq_datapath #(
    parameter int DEPTH     = aptq_pkg::DEPTH_DEF,
    parameter int AGE_BITS  = aptq_pkg::AGE_BITS_DEF,
    parameter int PRIO_BITS = aptq_pkg::PRIO_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  aptq_pkg::in_item_t  in_item,
    input  aptq_pkg::dp_cmd_t   cmd,
    output aptq_pkg::dp_sts_t   sts,
    input  logic [1:0]          policy,
    input  logic [15:0]         threshold,
    input  logic [4:0]          capacity,
    output aptq_pkg::out_item_t result
);
    import aptq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    logic [15:0]          task_mem  [DEPTH];
    logic [PRIO_BITS-1:0] prio_mem  [DEPTH];
    logic [AGE_BITS-1:0]  age_mem   [DEPTH];
    logic [IW-1:0]        order_mem [DEPTH];

    logic [CW-1:0] fill_reg, fill_next;
    in_item_t      in_reg;
    logic [IW-1:0] idx_reg, best_reg, sel_reg;
    logic          prio_reg, grant_age_reg;
    logic [IW-1:0] rank_reg;
    logic [CW-1:0] cap_eff;
    logic          full;
    logic [PRIO_BITS-1:0] in_prio;

    assign in_prio = in_reg.priority_req[PRIO_BITS-1:0];

    always_comb begin
        if (capacity == 5'd0) cap_eff = CW'(1);
        else if (32'(capacity) > DEPTH) cap_eff = CW'(DEPTH);
        else cap_eff = CW'(capacity);
    end
    assign full = !(fill_reg < cap_eff);

    // comparison of entry idx against current best
    logic take;
    always_comb begin
        if (!prio_reg && age_mem[idx_reg] != age_mem[best_reg])
            take = age_mem[idx_reg] > age_mem[best_reg];
        else if (prio_mem[idx_reg] != prio_mem[best_reg])
            take = prio_mem[idx_reg] > prio_mem[best_reg];
        else
            take = order_mem[idx_reg] < order_mem[best_reg];
    end

    logic [CW-1:0] last;
    assign last = fill_reg - CW'(1);

    assign sts.scan_last = (CW'(idx_reg) >= last);
    assign sts.need_scan = (fill_reg != '0);
    assign sts.prio_pass = 32'(age_mem[best_reg]) < 32'(threshold);
    // an emptied queue has nothing to fix up
    assign sts.fix_last  = (fill_reg == '0) || (CW'(idx_reg) >= last);
    assign sts.need_fix  = grant_age_reg;

    logic [IW-1:0] li;
    assign li = last[IW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.commit) begin
            if (in_reg.kind) begin
                if (fill_reg != '0) fill_next = last;
            end else if (!full) begin
                fill_next = fill_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) in_reg <= in_item;
        if (cmd.scan_clr) begin
            idx_reg  <= (DEPTH > 1) ? IW'(1) : '0;
            best_reg <= '0;
            grant_age_reg <= 1'b0;
        end
        if (cmd.load) prio_reg <= 1'b0;
        if (cmd.scan_step) begin
            if (in_reg.kind) begin
                if (CW'(idx_reg) < fill_reg && take) best_reg <= idx_reg;
            end else begin
                // drop-newest search reuses the scan: best holds the newest slot
                if (CW'(idx_reg) < fill_reg && CW'(order_mem[idx_reg]) == last)
                    best_reg <= idx_reg;
            end
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.decide) begin
            if (sts.prio_pass) begin
                prio_reg <= 1'b1;
                for (int i = 0; i < DEPTH; i++)
                    if (CW'(i) < fill_reg && age_mem[i] != AGE_MAX)
                        age_mem[i] <= age_mem[i] + AGE_BITS'(1);
            end
        end
        if (cmd.commit) begin
            result.reject_error <= 1'b0;
            result.occupancy    <= 5'(fill_next);
            if (in_reg.kind) begin
                if (fill_reg == '0) begin
                    result.status       <= ST_EMPTY;
                    result.out_task     <= '0;
                    result.out_priority <= '0;
                end else begin
                    result.status       <= ST_GRANTED;
                    result.out_task     <= task_mem[best_reg];
                    result.out_priority <= 8'(prio_mem[best_reg]);
                    rank_reg  <= order_mem[best_reg];
                    task_mem[best_reg]  <= task_mem[li];
                    prio_mem[best_reg]  <= prio_mem[li];
                    age_mem[best_reg]   <= age_mem[li];
                    order_mem[best_reg] <= order_mem[li];
                    idx_reg <= '0;
                    grant_age_reg <= 1'b1;
                end
            end else if (!full) begin
                task_mem[fill_reg[IW-1:0]]  <= in_reg.task_id;
                prio_mem[fill_reg[IW-1:0]]  <= in_prio;
                age_mem[fill_reg[IW-1:0]]   <= '0;
                order_mem[fill_reg[IW-1:0]] <= fill_reg[IW-1:0];
                result.status       <= ST_QUEUED;
                result.out_task     <= in_reg.task_id;
                result.out_priority <= 8'(in_prio);
            end else if (policy == POL_CALLER) begin
                result.status       <= ST_CALLER;
                result.out_task     <= in_reg.task_id;
                result.out_priority <= 8'(in_prio);
            end else if (policy == POL_DROPNEW) begin
                result.status       <= ST_DROPPED;
                result.out_task     <= task_mem[best_reg];
                result.out_priority <= 8'(prio_mem[best_reg]);
                task_mem[best_reg]  <= in_reg.task_id;
                prio_mem[best_reg]  <= in_prio;
                age_mem[best_reg]   <= '0;
            end else begin
                result.status       <= ST_REFUSED;
                result.out_task     <= in_reg.task_id;
                result.out_priority <= 8'(in_prio);
                result.reject_error <= (policy == POL_REJECT);
            end
        end
        if (cmd.compact) begin
            if (CW'(idx_reg) < fill_reg && order_mem[idx_reg] > rank_reg)
                order_mem[idx_reg] <= order_mem[idx_reg] - IW'(1);
            idx_reg <= idx_reg + IW'(1);
        end
    end

endmodule

// File: sv/aptq_ctrl.sv
// ----------------------------------------------------------------------------
// aptq_ctrl
// Sequencer: capture, scan passes, commit, order fix-up, result handoff.
// ----------------------------------------------------------------------------
module aptq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic              in_kind,
    output aptq_pkg::dp_cmd_t cmd,
    input  aptq_pkg::dp_sts_t sts
);
    import aptq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_START  = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_COMMIT = 7'b0010000,
        S_FIX    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   pass2_reg, pass2_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pass2_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass2_reg <= pass2_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pass2_next = pass2_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    pass2_next = 1'b0;
                    state_next = S_START;
                end
            end
            S_START: begin
                cmd.scan_clr = 1'b1;
                // offers scan too: finds the newest slot for a drop
                state_next = sts.need_scan ? S_SCAN : S_COMMIT;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = (in_kind && !pass2_reg) ? S_DECIDE : S_COMMIT;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                if (sts.prio_pass) begin
                    pass2_next = 1'b1;
                    state_next = S_START;
                end else begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = (in_kind && sts.need_scan) ? S_FIX : S_OUT;
            end
            S_FIX: begin
                cmd.compact = 1'b1;
                if (sts.fix_last) state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready and valid together");
    a_load_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid) else $error("result too early");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");

endmodule

// File: sv/aging_priority_task_queue.sv
// ----------------------------------------------------------------------------
// aging_priority_task_queue
// Bounded task queue with priority grant and age-based anti-starvation.
// ----------------------------------------------------------------------------
// Input beats (s_*) offer a task or poll; each beat yields one result beat
// (m_*). Config writes (cfg_*) set policy, age threshold and capacity; write
// them only while idle.
// One item at a time. Offer: one scan of the entries for the newest slot.
// Poll: one serial scan of the entries for the oldest, a second one when
// the priority path is taken, then a fix-up pass of the insertion ranks.
// The poll scans run serially through the single shared comparator.
// Reset empties the queue and loads register defaults; storage is not
// cleared. A result waits in the output register while m_ready is low and
// no new beat is taken until it leaves.
// ----------------------------------------------------------------------------
module aging_priority_task_queue #(
    parameter int DEPTH     = aptq_pkg::DEPTH_DEF,
    parameter int AGE_BITS  = aptq_pkg::AGE_BITS_DEF,
    parameter int PRIO_BITS = aptq_pkg::PRIO_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  aptq_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output aptq_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import aptq_pkg::*;

    logic [1:0]  policy_reg;
    logic [15:0] thresh_reg;
    logic [4:0]  cap_reg;
    dp_cmd_t     cmd;
    dp_sts_t     sts;
    logic        kind_q;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_REJECT;
            thresh_reg <= 16'd16;
            cap_reg    <= 5'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_POLICY:    policy_reg <= cfg_data[1:0];
                REG_THRESHOLD: thresh_reg <= cfg_data;
                REG_CAPACITY:  cap_reg    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) kind_q <= s_data.kind;
    end

    aptq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .in_kind(kind_q), .cmd(cmd), .sts(sts)
    );

    aptq_datapath #(.DEPTH(DEPTH), .AGE_BITS(AGE_BITS), .PRIO_BITS(PRIO_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_item(s_data), .cmd(cmd), .sts(sts),
        .policy(policy_reg), .threshold(thresh_reg), .capacity(cap_reg),
        .result(m_data)
    );

endmodule
